[rtl/utt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types, constants and the code point to UTF-16 unit mapping.
// ----------------------------------------------------------------------------
package utt_pkg;

    localparam int UTT_QDEPTH = 4;

    localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
    localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [7:0]  CONT_MASK    = 8'hC0;
    localparam logic [7:0]  CONT_TAG     = 8'h80;
    localparam logic [7:0]  SIX_BIT_MASK = 8'h3F;
    localparam logic [7:0]  ASCII_TOP    = 8'h7F;
    localparam logic [7:0]  CONT_TOP     = 8'hBF;
    localparam logic [7:0]  LEAD2_TOP    = 8'hDF;
    localparam logic [7:0]  LEAD3_TOP    = 8'hEF;

    // up to two 16-bit units for one code point
    typedef struct packed {
        logic [1:0]  n;
        logic [15:0] u0;
        logic [15:0] u1;
    } t_point_units;

    // one queue entry: the units that one input byte produces, in order
    typedef struct packed {
        logic [1:0]       n;
        logic [2:0][15:0] u;
    } t_entry;

    function automatic t_point_units point_units(input logic [31:0] cp, input logic en);
        t_point_units r;
        logic [31:0]  v;
        r = '0;
        v = cp - SUPP_BASE;
        if (en && cp <= CP_MAX) begin
            if (cp >= SUPP_BASE) begin
                r.n  = 2'd2;
                r.u0 = HI_SURR_BASE + {6'd0, v[19:10]};
                r.u1 = LO_SURR_BASE + {6'd0, v[9:0]};
            end else begin
                r.n  = 2'd1;
                r.u0 = cp[15:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/utt_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utt_ifs
// Valid/ready channel interfaces for the byte input and byte output streams.
// ----------------------------------------------------------------------------
interface utt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface utt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_run;

    modport source (output valid, output out_byte, output end_of_run, input ready);
    modport sink   (input valid, input out_byte, input end_of_run, output ready);
endinterface
`default_nettype wire

[rtl/utt_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utt_front
// Accepts UTF-8 bytes, runs the lenient decoder and queues the UTF-16 units
// each byte completes.
// ----------------------------------------------------------------------------
module utt_front
    import utt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    utt_in_if.sink      i_in,
    input  wire logic   i_full,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [31:0]  r_acc, n_acc;
    logic         r_pend, n_pend;
    logic         r_ended, n_ended;
    logic         accept;
    logic         cont;
    logic         last;
    logic [7:0]   b;
    logic [31:0]  new_acc;
    t_point_units pa, pb;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.in_byte;
    assign last       = i_in.is_last;
    assign cont       = (b & CONT_MASK) == CONT_TAG;

    always_comb begin
        priority if (b <= ASCII_TOP) begin
            new_acc = {24'd0, b};
        end else if (b <= CONT_TOP) begin
            new_acc = {r_acc[25:0], 6'd0} | {24'd0, b & SIX_BIT_MASK};
        end else if (b <= LEAD2_TOP) begin
            new_acc = {27'd0, b[4:0]};
        end else if (b <= LEAD3_TOP) begin
            new_acc = {28'd0, b[3:0]};
        end else begin
            new_acc = {29'd0, b[2:0]};
        end
    end

    // pending point closes on a non-continuation byte; the new one on the last byte
    assign pa = point_units(r_acc, !r_ended && r_pend && !cont);
    assign pb = point_units(new_acc, !r_ended && last && (b != 8'd0));

    always_comb begin
        o_entry.n    = 2'(pa.n + pb.n);
        o_entry.u[0] = (pa.n != 2'd0) ? pa.u0 : pb.u0;
        o_entry.u[1] = (pa.n == 2'd2) ? pa.u1 : ((pa.n == 2'd1) ? pb.u0 : pb.u1);
        o_entry.u[2] = (pa.n == 2'd2) ? pb.u0 : pb.u1;
        o_push       = accept && ((pa.n != 2'd0) || (pb.n != 2'd0));
    end

    always_comb begin
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_ended = r_ended;
        if (accept) begin
            if (r_ended) begin
                if (last) begin
                    n_ended = 1'b0;
                    n_acc   = '0;
                    n_pend  = 1'b0;
                end
            end else if (b == 8'd0) begin
                n_acc   = '0;
                n_pend  = 1'b0;
                n_ended = !last;
            end else if (last) begin
                n_acc  = '0;
                n_pend = 1'b0;
            end else begin
                n_acc  = new_acc;
                n_pend = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pend  <= 1'b0;
            r_ended <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_ended <= n_ended;
        end
    end

endmodule
`default_nettype wire

[rtl/utt_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utt_queue
// Short FIFO of decoded entries between the decoder and the serialiser.
// ----------------------------------------------------------------------------
module utt_queue
    import utt_pkg::*;
#(
    parameter int DEPTH = UTT_QDEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_entry      o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[rtl/utt_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utt_back
// Serialises queued UTF-16 units into bytes in the selected byte order.
// ----------------------------------------------------------------------------
module utt_back
    import utt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_big_endian,
    input  wire logic   i_valid,
    input  wire t_entry i_entry,
    output logic        o_pop,
    utt_out_if.source   o_out
);

    t_entry      r_ent, n_ent;
    logic        r_busy, n_busy;
    logic [2:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_end, n_out_end;
    logic        adv, fire, last_byte;
    logic [2:0]  last_idx;
    logic [15:0] unit;

    assign adv       = !r_out_valid || o_out.ready;
    assign fire      = r_busy && adv;
    assign last_idx  = {r_ent.n, 1'b0} - 3'd1;
    assign last_byte = r_idx == last_idx;
    assign o_pop     = i_valid && (!r_busy || (fire && last_byte));

    always_comb begin
        unique case (r_idx[2:1])
            2'd0:    unit = r_ent.u[0];
            2'd1:    unit = r_ent.u[1];
            default: unit = r_ent.u[2];
        endcase
    end

    always_comb begin
        n_ent       = r_ent;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_end   = r_out_end;
        if (adv) begin
            n_out_valid = r_busy;
        end
        if (fire) begin
            // odd byte of a unit is the high byte in little-endian order
            n_out_byte = (r_idx[0] ^ i_big_endian) ? unit[15:8] : unit[7:0];
            n_out_end  = last_byte;
            n_idx      = r_idx + 3'd1;
            if (last_byte) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_ent  = i_entry;
            n_idx  = '0;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_ent      <= n_ent;
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.end_of_run = r_out_end;

    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_ent.n != 2'd0))
        else $error("serialiser holds an empty entry");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= last_idx))
        else $error("byte index past end of entry");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_byte)
            && $stable(r_out_end)))
        else $error("output moved during stall");

endmodule
`default_nettype wire

[rtl/utf8_to_utf16_transcoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Lenient UTF-8 to UTF-16 byte stream transcoder with selectable byte order.
// ----------------------------------------------------------------------------
//  Port      Dir  Handshake        Payload
//  i_in      in   valid/ready      in_byte[7:0], is_last
//  o_out     out  valid/ready      out_byte[7:0], end_of_run
//  i_cfg_*   in   write enable     big_endian (bit 0 of i_cfg_wdata)
//
//  One input byte is taken per cycle while the unit queue has room; the
//  serialiser sends one output byte per cycle while the output is ready, so
//  an item yields two bytes per 16-bit unit it yields (two for ASCII, at most
//  six); one yielding no unit is not queued. The first output byte passes
//  through the queue, the serialiser's entry register, then the output
//  register. Synchronous active-low reset clears decoder state, queue and byte order.
//  Output stalls fill the queue and then hold off input; no data is dropped.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder
    import utt_pkg::*;
#(
    parameter int QDEPTH = UTT_QDEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    utt_in_if.sink          i_in,
    utt_out_if.source       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_wdata
);

    logic   r_big_endian;
    logic   push, full, pop, q_valid;
    t_entry push_entry, q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
        end else if (i_cfg_we) begin
            r_big_endian <= i_cfg_wdata[0];
        end
    end

    utt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    utt_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    utt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_big_endian (r_big_endian),
        .i_valid      (q_valid),
        .i_entry      (q_entry),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire
